### src/stag_pkg.sv
// Shared types, constants and AES helper functions for the session table gateway.
// Used by stag_front, stag_aes, stag_back and the top level.
package stag_pkg;

   // Byte 0 of a block is the most significant byte.
   typedef logic [0:15][7:0] blk_type;

   typedef enum logic [2:0] {
      ST_STORED      = 3'd0,
      ST_GW_MISMATCH = 3'd1,
      ST_STALE       = 3'd2,
      ST_DATA        = 3'd3,
      ST_UNKNOWN     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_WINDOW  = 2'd0,
      CSR_KEY_HI  = 2'd1,
      CSR_KEY_LO  = 2'd2,
      CSR_UNUSED  = 2'd3
   } csr_index_type;

   localparam logic OP_TOKEN = 1'b0;
   localparam logic [7:0] WINDOW_RESET = 8'd30;

   typedef struct packed {
      logic        opcode;
      logic [255:0] did;
      logic [7:0]  gw;
      blk_type     blk_a;
      blk_type     blk_b;
      logic [7:0]  now;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [127:0] plain;
      logic [7:0]  user_id;
      logic [6:0]  slot;
      logic        over;
   } rsp_type;

   localparam logic [0:255][7:0] SBOX = {
      256'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0,
      256'hb7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b275,
      256'h09832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
      256'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2,
      256'hcd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdb,
      256'he0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
      256'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9e,
      256'he1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16
   };

   localparam logic [0:255][7:0] INV_SBOX = {
      256'h52096ad53036a538bf40a39e81f3d7fb7ce339829b2fff87348e4344c4dee9cb,
      256'h547b9432a6c2233dee4c950b42fac34e082ea16628d924b2765ba2496d8bd125,
      256'h72f8f66486689816d4a45ccc5d65b6926c704850fdedb9da5e154657a78d9d84,
      256'h90d8ab008cbcd30af7e45805b8b34506d02c1e8fca3f0f02c1afbd0301138a6b,
      256'h3a9111414f67dcea97f2cfcef0b4e67396ac7422e7ad3585e2f937e81c75df6e,
      256'h47f11a711d29c5896fb7620eaa18be1bfc563e4bc6d279209adbc0fe78cd5af4,
      256'h1fdda8338807c731b11210592780ec5f60517fa919b54a0d2de57a9f93c99cef,
      256'ha0e03b4dae2af5b0c8ebbb3c83539961172b047eba77d626e169146355210c7d
   };

   function automatic logic [7:0] rcon(input logic [3:0] i);
      logic [7:0] r;
      unique case (i)
         4'd1: r = 8'h01;
         4'd2: r = 8'h02;
         4'd3: r = 8'h04;
         4'd4: r = 8'h08;
         4'd5: r = 8'h10;
         4'd6: r = 8'h20;
         4'd7: r = 8'h40;
         4'd8: r = 8'h80;
         4'd9: r = 8'h1b;
         4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Next round key of the forward schedule.
   function automatic blk_type key_fwd(input blk_type k, input logic [7:0] rc);
      blk_type n;
      logic [0:3][7:0] t;
      t = {SBOX[k[13]] ^ rc, SBOX[k[14]], SBOX[k[15]], SBOX[k[12]]};
      for (int j = 0; j < 4; j++) begin
         n[j] = k[j] ^ t[j];
         n[4 + j] = k[4 + j] ^ n[j];
         n[8 + j] = k[8 + j] ^ n[4 + j];
         n[12 + j] = k[12 + j] ^ n[8 + j];
      end
      return n;
   endfunction

   // Previous round key, undoing one forward step.
   function automatic blk_type key_bwd(input blk_type n, input logic [7:0] rc);
      blk_type o;
      logic [0:3][7:0] t;
      for (int j = 0; j < 4; j++) begin
         o[12 + j] = n[12 + j] ^ n[8 + j];
         o[8 + j] = n[8 + j] ^ n[4 + j];
         o[4 + j] = n[4 + j] ^ n[j];
      end
      t = {SBOX[o[13]] ^ rc, SBOX[o[14]], SBOX[o[15]], SBOX[o[12]]};
      for (int j = 0; j < 4; j++) o[j] = n[j] ^ t[j];
      return o;
   endfunction

   // One inverse round: shift rows, substitute, add key, then mix unless last.
   function automatic blk_type inv_round(input blk_type s, input blk_type rk, input logic mix);
      blk_type t, m;
      logic [7:0] a0, a1, a2, a3, a0x2, a1x2, a2x2, a3x2, a0x4, a1x4, a2x4, a3x4;
      logic [7:0] a0x8, a1x8, a2x8, a3x8;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            t[r + 4 * c] = INV_SBOX[s[r + 4 * ((c - r + 4) & 3)]] ^ rk[r + 4 * c];
      for (int c = 0; c < 4; c++) begin
         a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
         a0x2 = xt(a0); a1x2 = xt(a1); a2x2 = xt(a2); a3x2 = xt(a3);
         a0x4 = xt(a0x2); a1x4 = xt(a1x2); a2x4 = xt(a2x2); a3x4 = xt(a3x2);
         a0x8 = xt(a0x4); a1x8 = xt(a1x4); a2x8 = xt(a2x4); a3x8 = xt(a3x4);
         // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1.
         m[4 * c] = (a0x8 ^ a0x4 ^ a0x2) ^ (a1x8 ^ a1x2 ^ a1) ^ (a2x8 ^ a2x4 ^ a2) ^ (a3x8 ^ a3);
         m[4 * c + 1] = (a0x8 ^ a0) ^ (a1x8 ^ a1x4 ^ a1x2) ^ (a2x8 ^ a2x2 ^ a2)
                      ^ (a3x8 ^ a3x4 ^ a3);
         m[4 * c + 2] = (a0x8 ^ a0x4 ^ a0) ^ (a1x8 ^ a1) ^ (a2x8 ^ a2x4 ^ a2x2)
                      ^ (a3x8 ^ a3x2 ^ a3);
         m[4 * c + 3] = (a0x8 ^ a0x2 ^ a0) ^ (a1x8 ^ a1x4 ^ a1) ^ (a2x8 ^ a2)
                      ^ (a3x8 ^ a3x4 ^ a3x2);
      end
      return mix ? m : t;
   endfunction

endpackage

### src/stag_front.sv
// Front end: accepts request beats into a two-entry queue and tags them by kind.
// Depends on stag_pkg.
module stag_front
   import stag_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic [527:0] req_tdata,
   input  logic     req_tuser,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item_in;

   assign req_tready = (count_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = queue_ff[rd_ptr_ff];

   always_comb begin
      item_in.opcode = req_tuser;
      item_in.did = req_tdata[255:0];
      item_in.gw = req_tdata[263:256];
      item_in.blk_a = {req_tdata[327:264], req_tdata[391:328]};
      item_in.blk_b = {req_tdata[455:392], req_tdata[519:456]};
      item_in.now = req_tdata[527:520];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### src/stag_aes.sv
// Iterative AES-128 decryption: ten key schedule steps, then ten inverse rounds.
// Depends on stag_pkg.
module stag_aes
   import stag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  blk_type key,
   input  blk_type din,
   output logic    busy,
   output logic    done,
   output blk_type dout
);

   typedef enum logic [1:0] {A_IDLE, A_EXPAND, A_ROUND} aes_state_type;

   aes_state_type state_ff;
   blk_type       key_ff, st_ff, next_key, prev_key;
   logic [3:0]    cnt_ff;
   logic          done_ff;

   assign busy = (state_ff != A_IDLE);
   assign done = done_ff;
   assign dout = st_ff;
   assign next_key = key_fwd(key_ff, rcon(cnt_ff));
   assign prev_key = key_bwd(key_ff, rcon(cnt_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff <= 1'b0;
         cnt_ff <= 4'd0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            A_IDLE: begin
               if (start) begin
                  key_ff <= key;
                  st_ff <= din;
                  cnt_ff <= 4'd1;
                  state_ff <= A_EXPAND;
               end
            end
            A_EXPAND: begin
               key_ff <= next_key;
               if (cnt_ff == 4'd10) begin
                  st_ff <= st_ff ^ next_key;
                  state_ff <= A_ROUND;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            A_ROUND: begin
               // The round key in use is the one before the key held now.
               st_ff <= inv_round(st_ff, prev_key, cnt_ff != 4'd1);
               key_ff <= prev_key;
               if (cnt_ff == 4'd1) begin
                  state_ff <= A_IDLE;
                  done_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff - 4'd1;
               end
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

endmodule

### src/stag_back.sv
// Back end: token checks, session table search and store, data decryption.
// Depends on stag_pkg and stag_aes.
module stag_back
   import stag_pkg::*;
#(
   parameter int SESSIONS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output rsp_type     rsp_data
);

   localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int CNT_W = $clog2(SESSIONS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DEC_A, S_DEC_B, S_SCAN, S_RESOLVE, S_KEYRD, S_DEC_D, S_DONE
   } back_state_type;

   back_state_type state_ff;
   logic [7:0]     window_ff;
   blk_type        rkey_ff;
   item_type       item_ff;
   blk_type        plain_a_ff, plain_b_ff;
   rsp_type        res_ff, rsp_ff;
   logic           rsp_valid_ff;

   logic [255:0]   pseud_mem [SESSIONS];
   blk_type        key_mem [SESSIONS];
   logic [7:0]     uid_mem [SESSIONS];
   logic [SESSIONS-1:0] valid_ff;
   logic [255:0]   rd_ff;
   blk_type        key_rd_ff;
   logic [7:0]     uid_rd_ff;

   logic [CNT_W-1:0] addr_ff;
   logic           pend_ff;
   logic [IDX_W-1:0] cmp_idx_ff, hit_idx_ff, free_idx_ff, wr_idx;
   logic           hit_ff, free_ff, wr_en, wr_over, is_match;

   logic           aes_start, aes_busy, aes_done;
   blk_type        aes_key, aes_din, aes_dout;
   logic [7:0]     age;

   stag_aes u_aes (
      .clock (clock),
      .reset (reset),
      .start (aes_start),
      .key   (aes_key),
      .din   (aes_din),
      .busy  (aes_busy),
      .done  (aes_done),
      .dout  (aes_dout)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign is_match = pend_ff && valid_ff[cmp_idx_ff] && (rd_ff == item_ff.did);
   assign wr_over = !hit_ff && !free_ff;
   assign wr_idx = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : '0);
   assign wr_en = (state_ff == S_RESOLVE) && (item_ff.opcode == OP_TOKEN);
   assign age = item_ff.now - plain_a_ff[2];

   always_comb begin
      aes_start = 1'b0;
      aes_key = rkey_ff;
      aes_din = q_item.blk_a;
      unique case (state_ff)
         S_IDLE: aes_start = q_valid && (q_item.opcode == OP_TOKEN);
         S_DEC_A: begin
            aes_start = aes_done;
            aes_din = item_ff.blk_b;
         end
         S_KEYRD: begin
            aes_start = 1'b1;
            aes_key = key_rd_ff;
            aes_din = item_ff.blk_a;
         end
         default: aes_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pseud_mem[wr_idx] <= item_ff.did;
         key_mem[wr_idx] <= plain_b_ff;
         uid_mem[wr_idx] <= plain_a_ff[0];
      end
      rd_ff <= pseud_mem[addr_ff[IDX_W-1:0]];
      key_rd_ff <= key_mem[hit_idx_ff];
      uid_rd_ff <= uid_mem[hit_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         window_ff <= WINDOW_RESET;
         rkey_ff <= '0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_WINDOW: window_ff <= csr_wdata[7:0];
               CSR_KEY_HI: rkey_ff[0:7] <= csr_wdata;
               CSR_KEY_LO: rkey_ff[8:15] <= csr_wdata;
               default: window_ff <= window_ff;
            endcase
         end
         // The done state reloads the result register itself.
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff <= q_item;
                  res_ff <= '0;
                  addr_ff <= '0;
                  pend_ff <= 1'b0;
                  hit_ff <= 1'b0;
                  free_ff <= 1'b0;
                  state_ff <= (q_item.opcode == OP_TOKEN) ? S_DEC_A : S_SCAN;
               end
            end
            S_DEC_A: begin
               if (aes_done) begin
                  plain_a_ff <= aes_dout;
                  state_ff <= S_DEC_B;
               end
            end
            S_DEC_B: begin
               if (aes_done) begin
                  plain_b_ff <= aes_dout;
                  // The gateway check wins over the age check.
                  if (plain_a_ff[1] != item_ff.gw) begin
                     res_ff.status <= ST_GW_MISMATCH;
                     state_ff <= S_DONE;
                  end else if (!(age < window_ff)) begin
                     res_ff.status <= ST_STALE;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // The compare acts on the registered memory read, in the cycle after the read.
               if (addr_ff < CNT_W'(SESSIONS)) begin
                  pend_ff <= 1'b1;
                  cmp_idx_ff <= addr_ff[IDX_W-1:0];
                  addr_ff <= addr_ff + CNT_W'(1);
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff && !valid_ff[cmp_idx_ff] && !free_ff) begin
                  free_ff <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
               if (is_match) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= cmp_idx_ff;
                  state_ff <= S_RESOLVE;
               end else if (!pend_ff && addr_ff == CNT_W'(SESSIONS)) begin
                  state_ff <= S_RESOLVE;
               end
            end
            S_RESOLVE: begin
               if (item_ff.opcode == OP_TOKEN) begin
                  valid_ff[wr_idx] <= 1'b1;
                  res_ff.status <= ST_STORED;
                  res_ff.user_id <= plain_a_ff[0];
                  res_ff.slot <= 7'(wr_idx);
                  res_ff.over <= wr_over;
                  state_ff <= S_DONE;
               end else if (!hit_ff) begin
                  res_ff.status <= ST_UNKNOWN;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_KEYRD;
               end
            end
            S_KEYRD: begin
               res_ff.user_id <= uid_rd_ff;
               res_ff.slot <= 7'(hit_idx_ff);
               state_ff <= S_DEC_D;
            end
            S_DEC_D: begin
               if (aes_done) begin
                  res_ff.status <= ST_DATA;
                  res_ff.plain <= aes_dout;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_aes_start_idle: assert property (@(posedge clock) disable iff (reset)
      aes_start |-> !aes_busy)
      else $error("decryption started while the unit was busy");

   a_plain_only_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data.status != ST_DATA) |-> (rsp_data.plain == '0))
      else $error("plain text reported on a non-data result");

   a_overwrite_slot0: assert property (@(posedge clock) disable iff (reset)
      (wr_en && wr_over) |-> (wr_idx == '0))
      else $error("full table store did not go to slot 0");

endmodule

### src/session_table_aes_gateway_top.sv
// Session table gateway: AES-128 token check, pseudonym table and data decryption.
// A token goes through two iterated decryptions, then a linear table scan, one slot per
// cycle; a data beat goes through the table scan and then one decryption.
// One item is worked on at a time; the two-entry input queue and the result
// register let both sides keep moving. Reset is synchronous and clears the
// table's valid bits at once; no clearing pass is needed.
module session_table_aes_gateway_top
   import stag_pkg::*;
#(
   parameter int SESSIONS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // did_word_0..3, plain_gateway_id, first_block_hi/lo, second_block_hi/lo, now_seconds
   input  logic [527:0] req_tdata,
   // opcode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, plain_hi, plain_lo, user_id, slot_index, overwrote_slot, zero fill
   output logic [151:0] rsp_tdata
);

   logic     q_valid, q_pop;
   item_type q_item;
   rsp_type  rsp_data;

   stag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   stag_back #(.SESSIONS(SESSIONS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {5'b0, rsp_data.over, rsp_data.slot, rsp_data.user_id,
                       rsp_data.plain[63:0], rsp_data.plain[127:64], rsp_data.status};

endmodule
